/* hdl/p2r_pkg.sv */
// Shared types and constants for the pixel to RGBA8 expander.
`default_nettype none
package p2r_pkg;

   localparam int COMP_W   = 32;
   localparam int CNT_W    = 3;
   localparam int CSR_IDX_W = 1;
   localparam int PROD_W   = 32;
   localparam int RND_W    = 33;
   localparam int FIX_W    = 35;
   localparam int FRAC_W   = 26;
   localparam int SH_W     = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_COMPONENT_COUNT  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOAT_COMPONENTS = 1'd1;

   localparam logic [CNT_W-1:0] CNT_RESET = 3'd4;
   localparam logic [7:0] EXP_ONE = 8'd127;
   localparam logic [7:0] EXP_MAX = 8'd255;
   localparam logic [7:0] EXP_BIAS_SH = 8'd126;
   localparam logic [7:0] SCALE_255 = 8'd255;
   localparam logic [7:0] OPAQUE = 8'hFF;

   typedef enum logic {
      KIND_CONST,
      KIND_CALC
   } kind_type;

   typedef enum logic [1:0] {
      MODE_GRAY,
      MODE_GRAY_ALPHA,
      MODE_RGB,
      MODE_RGBA
   } mode_type;

   typedef struct packed {
      logic en1;
      logic en2;
      logic en3;
   } lane_ctl_type;

   typedef struct packed {
      kind_type          kind;
      logic [7:0]        val;
      logic [PROD_W-1:0] prod;
      logic [7:0]        expo;
   } st1_type;

   typedef struct packed {
      kind_type         kind;
      logic [7:0]       val;
      logic [FIX_W-1:0] fix;
      logic [SH_W-1:0]  sh;
   } st2_type;

endpackage
`default_nettype wire

/* hdl/p2r_lane.sv */
// One component lane: byte pass or float32 to 8-bit quantizer, three stages.
`default_nettype none
module p2r_lane (
   input  wire logic                       clock,
   input  wire logic                       float_mode,
   input  wire logic [p2r_pkg::COMP_W-1:0] comp,
   input  wire p2r_pkg::lane_ctl_type      ctl,
   output logic [7:0]                      value
);

   p2r_pkg::st1_type s1_ff, s1_in;
   p2r_pkg::st2_type s2_ff, s2_in;
   logic [7:0] value_ff, value_in;

   // stage 1: classify, mantissa times 255
   always_comb begin
      logic       sgn;
      logic [7:0] e;
      logic [22:0] man;
      sgn = comp[31];
      e   = comp[30:23];
      man = comp[22:0];
      s1_in.expo = e;
      s1_in.prod = {1'b1, man} * p2r_pkg::SCALE_255;
      s1_in.kind = p2r_pkg::KIND_CONST;
      s1_in.val  = 8'd0;
      if (!float_mode) begin
         s1_in.val = comp[7:0];
      end else if (sgn || e == 8'd0 || (e == p2r_pkg::EXP_MAX && man != 23'd0)) begin
         s1_in.val = 8'd0;
      end else if (e >= p2r_pkg::EXP_ONE) begin
         s1_in.val = p2r_pkg::OPAQUE;
      end else begin
         s1_in.kind = p2r_pkg::KIND_CALC;
      end
   end

   // stage 2: round product to 24 bits, fixed point with 26 fraction bits before shift
   always_comb begin
      logic                       up;
      logic [p2r_pkg::RND_W-1:0]  r;
      if (s1_ff.prod[31]) begin
         up = s1_ff.prod[7] & ((|s1_ff.prod[6:0]) | s1_ff.prod[8]);
         r  = (p2r_pkg::RND_W'(s1_ff.prod[31:8]) + p2r_pkg::RND_W'(up)) << 8;
      end else begin
         up = s1_ff.prod[6] & ((|s1_ff.prod[5:0]) | s1_ff.prod[7]);
         r  = (p2r_pkg::RND_W'(s1_ff.prod[30:7]) + p2r_pkg::RND_W'(up)) << 7;
      end
      s2_in.kind = s1_ff.kind;
      s2_in.val  = s1_ff.val;
      s2_in.fix  = {r, 2'b00};
      s2_in.sh   = p2r_pkg::SH_W'(p2r_pkg::EXP_BIAS_SH - s1_ff.expo);
   end

   // stage 3: align, add one half, round to single, truncate
   always_comb begin
      logic [p2r_pkg::FIX_W-1:0]  x;
      logic [p2r_pkg::FIX_W-1:0]  sum;
      logic [7:0]                 ipart;
      logic [p2r_pkg::FRAC_W-1:0] frac;
      logic [p2r_pkg::FRAC_W-1:0] mask;
      logic [4:0]                 lb;
      logic                       carry;
      if (s2_ff.sh >= p2r_pkg::SH_W'(p2r_pkg::FIX_W)) begin
         x = '0;
      end else begin
         x = s2_ff.fix >> s2_ff.sh;
      end
      sum   = x + (p2r_pkg::FIX_W'(1) << (p2r_pkg::FRAC_W - 1));
      ipart = sum[p2r_pkg::FRAC_W +: 8];
      frac  = sum[p2r_pkg::FRAC_W-1:0];
      lb    = 5'd1;
      for (int i = 0; i < 8; i++) begin
         if (ipart[i]) begin
            lb = 5'(i + 2);
         end
      end
      mask  = (p2r_pkg::FRAC_W'(1) << lb) - p2r_pkg::FRAC_W'(1);
      carry = &(frac | mask);
      if (s2_ff.kind == p2r_pkg::KIND_CALC) begin
         value_in = ipart + 8'(carry);
      end else begin
         value_in = s2_ff.val;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en1) begin
         s1_ff <= s1_in;
      end
      if (ctl.en2) begin
         s2_ff <= s2_in;
      end
      if (ctl.en3) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule
`default_nettype wire

/* hdl/p2r_merge.sv */
// Merge stage: maps lane values to RGBA by component count, output register.
`default_nettype none
module p2r_merge (
   input  wire logic                      clock,
   input  wire logic                      load,
   input  wire logic [p2r_pkg::CNT_W-1:0] comp_count,
   input  wire logic [7:0]                lane0,
   input  wire logic [7:0]                lane1,
   input  wire logic [7:0]                lane2,
   input  wire logic [7:0]                lane3,
   output logic [7:0]                     red,
   output logic [7:0]                     green,
   output logic [7:0]                     blue,
   output logic [7:0]                     alpha
);

   p2r_pkg::mode_type mode;
   logic [7:0] red_ff, green_ff, blue_ff, alpha_ff;
   logic [7:0] red_in, green_in, blue_in, alpha_in;

   always_comb begin
      unique case (comp_count)
         3'd0, 3'd1: mode = p2r_pkg::MODE_GRAY;
         3'd2:       mode = p2r_pkg::MODE_GRAY_ALPHA;
         3'd3:       mode = p2r_pkg::MODE_RGB;
         default:    mode = p2r_pkg::MODE_RGBA;
      endcase
   end

   always_comb begin
      unique case (mode)
         p2r_pkg::MODE_GRAY: begin
            red_in = lane0; green_in = lane0; blue_in = lane0; alpha_in = p2r_pkg::OPAQUE;
         end
         p2r_pkg::MODE_GRAY_ALPHA: begin
            red_in = lane0; green_in = lane0; blue_in = lane0; alpha_in = lane1;
         end
         p2r_pkg::MODE_RGB: begin
            red_in = lane0; green_in = lane1; blue_in = lane2; alpha_in = p2r_pkg::OPAQUE;
         end
         default: begin
            red_in = lane0; green_in = lane1; blue_in = lane2; alpha_in = lane3;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         alpha_ff <= alpha_in;
      end
   end

   assign red   = red_ff;
   assign green = green_ff;
   assign blue  = blue_ff;
   assign alpha = alpha_ff;

endmodule
`default_nettype wire

/* hdl/pixel_to_rgba8_expander.sv */
// Top level: one to four byte or float32 components in, one RGBA8 pixel out.
//
// req_ channel carries one pixel per item (req_comp0..3); rsp_ channel
// returns one RGBA8 item per input item, in order. Both channels use
// valid/stall; an item moves when valid is high and stall is low.
// csr_ writes component_count (index 0, values 0..7: 0 reads as 1, 5..7
// as 4) and float_components (index 1); write only while the block holds
// no items. rsp_valid follows the accepting edge through four registers:
// three lane stages - multiply by 255, round to single, align/add half/round
// - then the merge register. Throughput: one item per cycle while rsp_stall
// is low, set by the four lanes each taking one component per cycle.
// Each stage holds its item while the next is full and stalled, so bubbles
// are squeezed out and up to four items are in flight; req_stall rises only
// when every stage is full and rsp_stall is high.
// Reset empties the pipeline and sets four byte components.
`default_nettype none
module pixel_to_rgba8_expander (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [p2r_pkg::COMP_W-1:0]    req_comp0,
   input  wire logic [p2r_pkg::COMP_W-1:0]    req_comp1,
   input  wire logic [p2r_pkg::COMP_W-1:0]    req_comp2,
   input  wire logic [p2r_pkg::COMP_W-1:0]    req_comp3,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [7:0]                         rsp_red,
   output logic [7:0]                         rsp_green,
   output logic [7:0]                         rsp_blue,
   output logic [7:0]                         rsp_alpha,
   input  wire logic                          csr_we,
   input  wire logic [p2r_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [p2r_pkg::CNT_W-1:0]     csr_wdata
);

   logic [p2r_pkg::CNT_W-1:0] cnt_ff;
   logic flt_ff;
   logic v1_ff, v2_ff, v3_ff, out_ff;
   logic v1_in, v2_in, v3_in, out_in;
   logic en1, en2, en3, en_out;
   p2r_pkg::lane_ctl_type ctl;
   logic [7:0] lane_val [4];

   assign en_out = !out_ff || !rsp_stall;
   assign en3    = !v3_ff || en_out;
   assign en2    = !v2_ff || en3;
   assign en1    = !v1_ff || en2;

   assign req_stall = !en1;
   assign rsp_valid = out_ff;

   assign v1_in  = en1 ? req_valid : v1_ff;
   assign v2_in  = en2 ? v1_ff : v2_ff;
   assign v3_in  = en3 ? v2_ff : v3_ff;
   assign out_in = en_out ? v3_ff : out_ff;

   assign ctl.en1 = en1;
   assign ctl.en2 = en2;
   assign ctl.en3 = en3;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= p2r_pkg::CNT_RESET;
         flt_ff <= 1'b0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         out_ff <= 1'b0;
      end else begin
         v1_ff  <= v1_in;
         v2_ff  <= v2_in;
         v3_ff  <= v3_in;
         out_ff <= out_in;
         if (csr_we) begin
            unique case (csr_index)
               p2r_pkg::CSR_COMPONENT_COUNT:  cnt_ff <= csr_wdata;
               p2r_pkg::CSR_FLOAT_COMPONENTS: flt_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   p2r_lane u_lane0 (.clock(clock), .float_mode(flt_ff), .comp(req_comp0), .ctl(ctl),
                     .value(lane_val[0]));
   p2r_lane u_lane1 (.clock(clock), .float_mode(flt_ff), .comp(req_comp1), .ctl(ctl),
                     .value(lane_val[1]));
   p2r_lane u_lane2 (.clock(clock), .float_mode(flt_ff), .comp(req_comp2), .ctl(ctl),
                     .value(lane_val[2]));
   p2r_lane u_lane3 (.clock(clock), .float_mode(flt_ff), .comp(req_comp3), .ctl(ctl),
                     .value(lane_val[3]));

   p2r_merge u_merge (
      .clock      (clock),
      .load       (en_out),
      .comp_count (cnt_ff),
      .lane0      (lane_val[0]),
      .lane1      (lane_val[1]),
      .lane2      (lane_val[2]),
      .lane3      (lane_val[3]),
      .red        (rsp_red),
      .green      (rsp_green),
      .blue       (rsp_blue),
      .alpha      (rsp_alpha)
   );

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff && out_ff))
      else $error("input stalled with an empty stage");

   a_stage3_to_out: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && en3) |=> rsp_valid)
      else $error("item lost between last lane stage and output");

   a_stage2_hold: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !en2) |=> (v2_ff && v3_ff))
      else $error("held item dropped in stage two");

endmodule
`default_nettype wire

/* test/tb_pixel_to_rgba8_expander.sv */
// Testbench for pixel_to_rgba8_expander: directed table plus random pixels checked by a predictor.
`timescale 1ns / 1ps
module tb_pixel_to_rgba8_expander;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } rgba_type;

   typedef struct {
      logic [2:0]  cnt;
      logic        flt;
      logic [31:0] c0, c1, c2, c3;
      bit          typed;
      rgba_type    px;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [31:0] req_comp0 = '0, req_comp1 = '0, req_comp2 = '0, req_comp3 = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [7:0] rsp_red, rsp_green, rsp_blue, rsp_alpha;
   logic csr_we = 1'b0;
   logic [p2r_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [p2r_pkg::CNT_W-1:0] csr_wdata = '0;

   rgba_type pixel_q[$];
   dir_row_type dir_tab[$];
   logic [2:0] model_count = p2r_pkg::CNT_RESET;
   logic model_float = 1'b0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int errors = 0;
   int stuck_cycles = 0;

   pixel_to_rgba8_expander dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_comp0(req_comp0), .req_comp1(req_comp1),
      .req_comp2(req_comp2), .req_comp3(req_comp3),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_red(rsp_red), .rsp_green(rsp_green),
      .rsp_blue(rsp_blue), .rsp_alpha(rsp_alpha),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // round to 24 significant bits, nearest-even, same scale
   function automatic logic [127:0] round24(logic [127:0] x);
      int msb;
      int s;
      logic [127:0] keep, rem, half;
      msb = -1;
      for (int i = 0; i < 128; i++) if (x[i]) msb = i;
      if (msb < 24) return x;
      s = msb - 23;
      keep = x >> s;
      rem = x - (keep << s);
      half = 128'd1 << (s - 1);
      if (rem > half || (rem == half && keep[0])) keep = keep + 1;
      return keep << s;
   endfunction

   function automatic logic [7:0] quantize(logic [31:0] bits);
      logic [7:0] ex;
      logic [22:0] frac;
      logic [127:0] p, x, y;
      int k;
      ex = bits[30:23];
      frac = bits[22:0];
      if (bits[31] || bits[30:0] == 0 || (ex == 8'hFF && frac != 0)) return 8'd0;
      if (ex >= p2r_pkg::EXP_ONE) return 8'd255;
      p = (ex == 0) ? 128'(frac) : 128'({1'b1, frac});
      k = (ex == 0) ? -149 : int'(ex) - 150;
      p = round24(p * 128'd255);
      if (k < -60) return 8'd0;
      x = (p << (k + 60)) + (128'd1 << 59);
      y = round24(x);
      return y[67:60];
   endfunction

   function automatic logic [7:0] comp_value(logic [31:0] c);
      return model_float ? quantize(c) : c[7:0];
   endfunction

   function automatic rgba_type expand_pixel(logic [31:0] c0, c1, c2, c3);
      rgba_type px;
      int n;
      n = (model_count < 1) ? 1 : (model_count > 4) ? 4 : model_count;
      px.red = comp_value(c0);
      px.green = (n >= 3) ? comp_value(c1) : px.red;
      px.blue = (n >= 3) ? comp_value(c2) : px.red;
      px.alpha = (n == 2) ? comp_value(c1) : (n == 4) ? comp_value(c3) : p2r_pkg::OPAQUE;
      return px;
   endfunction

   function automatic void add_row(dir_row_type row);
      dir_tab.insert(dir_tab.size(), row);
   endfunction

   task automatic set_config(logic [2:0] cnt, logic flt);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= p2r_pkg::CSR_COMPONENT_COUNT;
      csr_wdata <= cnt;
      @(posedge clock);
      csr_index <= p2r_pkg::CSR_FLOAT_COMPONENTS;
      csr_wdata <= p2r_pkg::CNT_W'(flt);
      @(posedge clock);
      csr_we <= 1'b0;
      model_count = cnt;
      model_float = flt;
   endtask

   task automatic send_pixel(logic [31:0] c0, c1, c2, c3, bit typed, rgba_type px);
      rgba_type exp_px;
      req_valid <= 1'b1;
      req_comp0 <= c0;
      req_comp1 <= c1;
      req_comp2 <= c2;
      req_comp3 <= c3;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      exp_px = typed ? px : expand_pixel(c0, c1, c2, c3);
      pixel_q.insert(pixel_q.size(), exp_px);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   function automatic logic [31:0] rand_comp();
      if (!model_float) return $urandom;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return {1'b0, 8'($urandom_range(96, 126)), 23'($urandom)};
         6: return $urandom;
         7: return {24'h3F7FFF, 8'($urandom)};
         8: begin
            case ($urandom_range(0, 5))
               0: return 32'h3F800000;
               1: return 32'h3F000000;
               2: return 32'h00000000;
               3: return 32'h7F800000;
               4: return 32'h7FC00000;
               default: return 32'h80000000;
            endcase
         end
         default: return {1'b0, 8'($urandom_range(0, 95)), 23'($urandom)};
      endcase
   endfunction

   // result side: random stall, compare against oldest expected item
   always @(posedge clock) begin
      rgba_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pixel_q.size() == 0) begin
            $error("unexpected item red=%h green=%h blue=%h alpha=%h",
                   rsp_red, rsp_green, rsp_blue, rsp_alpha);
            errors++;
         end else begin
            want = pixel_q.pop_front();
            if (rsp_red !== want.red) begin
               $error("red expected %h got %h", want.red, rsp_red);
               errors++;
            end
            if (rsp_green !== want.green) begin
               $error("green expected %h got %h", want.green, rsp_green);
               errors++;
            end
            if (rsp_blue !== want.blue) begin
               $error("blue expected %h got %h", want.blue, rsp_blue);
               errors++;
            end
            if (rsp_alpha !== want.alpha) begin
               $error("alpha expected %h got %h", want.alpha, rsp_alpha);
               errors++;
            end
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles > 5000) begin
         $display("[pixel_to_rgba8_expander] ERROR");
         $finish;
      end
   end

   initial begin
      int n;
      add_row('{3'd4, 1'b0, 32'hFFFFFFFF, 32'h00000000, 32'hAAAAAA80, 32'h5555557F,
                1, '{8'hFF, 8'h00, 8'h80, 8'h7F}});
      add_row('{3'd4, 1'b0, 32'h00000000, 32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF,
                1, '{8'h00, 8'hFF, 8'h00, 8'hFF}});
      add_row('{3'd1, 1'b0, 32'hFFFFFF12, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                1, '{8'h12, 8'h12, 8'h12, 8'hFF}});
      add_row('{3'd2, 1'b0, 32'h00000034, 32'h12345656, 32'hFFFFFFFF, 32'h0,
                1, '{8'h34, 8'h34, 8'h34, 8'h56}});
      add_row('{3'd3, 1'b0, 32'h1, 32'h2, 32'h3, 32'hFF,
                1, '{8'h01, 8'h02, 8'h03, 8'hFF}});
      add_row('{3'd0, 1'b0, 32'h9A, 32'h11, 32'h22, 32'h33,
                1, '{8'h9A, 8'h9A, 8'h9A, 8'hFF}});
      add_row('{3'd7, 1'b0, 32'h1, 32'h2, 32'h3, 32'h4,
                1, '{8'h01, 8'h02, 8'h03, 8'h04}});
      add_row('{3'd5, 1'b0, 32'hDEADBEEF, 32'h01234567, 32'h89ABCDEF, 32'h76543210,
                0, '0});
      add_row('{3'd4, 1'b1, 32'h3F800000, 32'h00000000, 32'h80000000, 32'h7FC00000,
                1, '{8'hFF, 8'h00, 8'h00, 8'h00}});
      add_row('{3'd4, 1'b1, 32'h7F800000, 32'hFF800000, 32'h3F000000, 32'h00000001,
                1, '{8'hFF, 8'h00, 8'h80, 8'h00}});
      add_row('{3'd4, 1'b1, 32'h3F7FFFFF, 32'h00800000, 32'h7F7FFFFF, 32'hBF800000,
                0, '0});
      add_row('{3'd4, 1'b1, 32'h007FFFFF, 32'h3B808081, 32'h3C000000, 32'hFFFFFFFF,
                0, '0});
      add_row('{3'd1, 1'b1, 32'h3E800000, 32'hFFFFFFFF, 32'h0, 32'h0,
                1, '{8'h40, 8'h40, 8'h40, 8'hFF}});
      add_row('{3'd2, 1'b1, 32'h3F400000, 32'h3F800000, 32'h0, 32'h0,
                1, '{8'hBF, 8'hBF, 8'hBF, 8'hFF}});
      add_row('{3'd3, 1'b1, 32'h3DCCCCCD, 32'h3EAAAAAB, 32'h3F7F0000, 32'h7FFFFFFF,
                0, '0});
      add_row('{3'd6, 1'b1, 32'h3A800000, 32'h3C808081, 32'h3F7EFEFF, 32'h3E000000,
                0, '0});
      add_row('{3'd0, 1'b1, 32'h3F7FFF00, 32'h0, 32'h0, 32'h0, 0, '0});

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 14;
      recv_idle_pct = 69;
      foreach (dir_tab[i]) begin
         if (dir_tab[i].cnt != model_count || dir_tab[i].flt != model_float)
            set_config(dir_tab[i].cnt, dir_tab[i].flt);
         send_pixel(dir_tab[i].c0, dir_tab[i].c1, dir_tab[i].c2, dir_tab[i].c3,
                    dir_tab[i].typed, dir_tab[i].px);
      end

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 69 : 0;
         recv_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 14 : 0;
         n = 0;
         while (n < 300) begin
            set_config(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            repeat ($urandom_range(20, 60)) begin
               send_pixel(rand_comp(), rand_comp(), rand_comp(), rand_comp(), 0, '0);
               n++;
            end
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("[pixel_to_rgba8_expander] OK");
      else
         $display("[pixel_to_rgba8_expander] ERROR");
      $finish;
   end
endmodule
